FILE: src/iba_pkg.sv
// Shared types and codes for the inode block allocator.
`default_nettype none
package iba_pkg;

  localparam int NUM_BLOCKS      = 128;
  localparam int NUM_INODES      = 16;
  localparam int MAX_FILE_BLOCKS = 8;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_RANGE     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FIND,
    S_FIND_WAIT,
    S_ALLOC,
    S_ALLOC_DONE,
    S_FREE_RD,
    S_FREE_WAIT,
    S_FREE_BIT,
    S_LOOK_RD,
    S_LOOK_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic inode_clr;
    logic blk_clr;
    logic inode_step;
    logic blk_step;
    logic ptr_step;
    logic alloc_take;
    logic commit_create;
    logic free_take;
    logic commit_delete;
    logic look_rd;
    logic look_cap;
    logic set_status;
    status_t status;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  size_bad;
    logic  table_full;
    logic  no_space;
    logic  inode_last;
    logic  inode_hit;
    logic  blk_last;
    logic  blk_free;
    logic  alloc_done;
    logic  idx_range;
  } stat_t;

endpackage
`default_nettype wire

FILE: src/iba_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module iba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/iba_ctrl.sv
// Controller state machine for the allocator.
`default_nettype none
module iba_ctrl import iba_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t st,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CHECK;
      S_CHECK: begin
        case (st.kind)
          KIND_CREATE: state_nxt = (st.size_bad || st.table_full || st.no_space) ?
                                   S_RESP : S_FIND;
          KIND_DELETE, KIND_LOOKUP: state_nxt = S_FIND;
          default: state_nxt = S_RESP;
        endcase
      end
      S_FIND: begin
        if (st.inode_hit) begin
          case (st.kind)
            KIND_CREATE: state_nxt = S_ALLOC;
            KIND_DELETE: state_nxt = S_FREE_RD;
            default:     state_nxt = S_LOOK_RD;
          endcase
        end else if (st.inode_last) state_nxt = S_RESP;
      end
      S_ALLOC:      if (st.alloc_done || st.blk_last) state_nxt = S_ALLOC_DONE;
      S_ALLOC_DONE: state_nxt = S_RESP;
      S_FREE_RD:    state_nxt = st.alloc_done ? S_RESP : S_FREE_WAIT;
      S_FREE_WAIT:  state_nxt = S_FREE_BIT;
      S_FREE_BIT:   state_nxt = S_FREE_RD;
      S_LOOK_RD:    state_nxt = st.idx_range ? S_RESP : S_LOOK_WAIT;
      S_LOOK_WAIT:  state_nxt = S_RESP;
      S_RESP:       if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = ST_OK;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: if (in_valid) cmd.load = 1'b1;
      S_CHECK: begin
        cmd.inode_clr = 1'b1;
        cmd.blk_clr   = 1'b1;
        if (st.kind == KIND_CREATE) begin
          if (st.size_bad) begin
            cmd.set_status = 1'b1; cmd.status = ST_BAD_SIZE;
          end else if (st.table_full) begin
            cmd.set_status = 1'b1; cmd.status = ST_FULL;
          end else if (st.no_space) begin
            cmd.set_status = 1'b1; cmd.status = ST_NO_SPACE;
          end
        end
      end
      S_FIND: begin
        if (!st.inode_hit) begin
          cmd.inode_step = 1'b1;
          if (st.inode_last) begin
            cmd.set_status = 1'b1;
            cmd.status = (st.kind == KIND_CREATE) ? ST_FULL : ST_NOT_FOUND;
          end
        end
      end
      S_ALLOC: begin
        if (!st.alloc_done) begin
          cmd.blk_step = 1'b1;
          if (st.blk_free) cmd.alloc_take = 1'b1;
        end
      end
      S_ALLOC_DONE: cmd.commit_create = 1'b1;
      S_FREE_RD: begin
        if (st.alloc_done) cmd.commit_delete = 1'b1;
      end
      S_FREE_BIT: begin
        cmd.free_take = 1'b1;
        cmd.ptr_step  = 1'b1;
      end
      S_LOOK_RD: begin
        if (st.idx_range) begin
          cmd.set_status = 1'b1; cmd.status = ST_RANGE;
        end else cmd.look_rd = 1'b1;
      end
      S_LOOK_WAIT: cmd.look_cap = 1'b1;
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.resp_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: src/iba_dp.sv
// Datapath: block map, inode table, pointer memory and result register.
`default_nettype none
module iba_dp import iba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            st,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_file_name,
  input  wire logic [3:0]  in_size_blocks,
  input  wire logic [3:0]  in_block_index,
  output logic      [2:0]  out_status,
  output logic      [6:0]  out_block_address,
  output logic      [3:0]  out_inode_slot,
  output logic      [6:0]  out_free_blocks,
  output logic      [4:0]  out_file_count
);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int IW = $clog2(NUM_INODES);
  localparam int KW = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
  localparam int PD = NUM_INODES * MAX_FILE_BLOCKS;
  localparam int PW = $clog2(PD);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int FW = $clog2(NUM_INODES + 1);

  logic [NUM_BLOCKS-1:0] map_r;
  logic [NUM_INODES-1:0] used_r;
  logic [63:0]           names_r [NUM_INODES];
  logic [3:0]            sizes_r [NUM_INODES];
  logic [CW-1:0]         fcnt_r;
  logic [FW-1:0]         files_r;

  kind_t       kind_r;
  logic [63:0] name_r;
  logic [3:0]  size_r, idx_r;
  logic [IW-1:0] islot_r;
  logic [BW-1:0] bidx_r;
  logic [4:0]  got_r;
  status_t     status_r;
  logic [6:0]  addr_r;

  logic [63:0] norm;
  logic        stop;
  always_comb begin
    norm = '0;
    stop = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (in_file_name[8*b +: 8] == 8'd0) stop = 1'b1;
      if (!stop) norm[8*b +: 8] = in_file_name[8*b +: 8];
    end
  end

  logic          p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [BW-1:0] p_rdata;
  logic [KW-1:0] got_k, idx_k;

  assign got_k   = got_r[KW-1:0];
  assign idx_k   = idx_r[KW-1:0];
  assign p_we    = cmd.alloc_take;
  assign p_waddr = PW'({islot_r, got_k});
  assign p_raddr = cmd.look_rd ? PW'({islot_r, idx_k}) : PW'({islot_r, got_k});

  iba_ram #(.WIDTH(BW), .DEPTH(PD)) u_ptr (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(bidx_r),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  logic [4:0] cur_size;
  assign cur_size = {1'b0, sizes_r[islot_r]};

  always_comb begin
    st.kind       = kind_r;
    st.size_bad   = (size_r == 4'd0) || (32'(size_r) > MAX_FILE_BLOCKS);
    st.table_full = (32'(files_r) >= NUM_INODES);
    st.no_space   = (32'(size_r) > 32'(fcnt_r));
    st.inode_last = (32'(islot_r) == NUM_INODES - 1);
    st.inode_hit  = (kind_r == KIND_CREATE) ? !used_r[islot_r] :
                    (used_r[islot_r] && names_r[islot_r] == name_r);
    st.blk_last   = (32'(bidx_r) == NUM_BLOCKS - 1);
    st.blk_free   = !map_r[bidx_r];
    st.alloc_done = (kind_r == KIND_CREATE) ? (got_r == {1'b0, size_r}) :
                    (got_r >= cur_size || 32'(got_r) >= MAX_FILE_BLOCKS);
    st.idx_range  = ({1'b0, idx_r} >= cur_size) || (32'(idx_r) >= MAX_FILE_BLOCKS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r   <= NUM_BLOCKS'(1);
      used_r  <= '0;
      fcnt_r  <= CW'(NUM_BLOCKS - 1);
      files_r <= '0;
    end else begin
      if (cmd.alloc_take) map_r[bidx_r] <= 1'b1;
      if (cmd.free_take && map_r[p_rdata]) begin
        map_r[p_rdata] <= 1'b0;
        fcnt_r <= fcnt_r + CW'(1);
      end
      if (cmd.commit_create) begin
        used_r[islot_r] <= 1'b1;
        files_r <= files_r + FW'(1);
        fcnt_r  <= fcnt_r - CW'(got_r);
      end
      if (cmd.commit_delete) begin
        used_r[islot_r] <= 1'b0;
        if (files_r != '0) files_r <= files_r - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= kind_t'(in_kind);
      name_r   <= norm;
      size_r   <= in_size_blocks;
      idx_r    <= in_block_index;
      status_r <= ST_OK;
      addr_r   <= '0;
    end
    if (cmd.inode_clr) islot_r <= '0;
    else if (cmd.inode_step && !st.inode_last) islot_r <= islot_r + IW'(1);
    if (cmd.blk_clr) begin
      bidx_r <= BW'(1);
      got_r  <= '0;
    end else begin
      if (cmd.blk_step) bidx_r <= bidx_r + BW'(1);
      if (cmd.alloc_take || cmd.ptr_step) got_r <= got_r + 5'd1;
    end
    if (cmd.commit_create) begin
      names_r[islot_r] <= name_r;
      sizes_r[islot_r] <= got_r[3:0];
    end
    if (cmd.set_status) status_r <= cmd.status;
    if (cmd.look_cap) addr_r <= 7'(p_rdata);
    if (cmd.resp_load) begin
      out_status        <= status_r;
      out_block_address <= addr_r;
      out_inode_slot    <= (status_r == ST_OK || status_r == ST_RANGE) &&
                           kind_r != KIND_NONE ? 4'(islot_r) : 4'd0;
      out_free_blocks   <= 7'(fcnt_r);
      out_file_count    <= 5'(files_r);
    end
  end
endmodule
`default_nettype wire

FILE: src/inode_block_allocator_core.sv
// Top level of the inode block allocator.
//   channel | direction | ports
//   request | in        | in_valid, in_stall, in_kind, in_file_name, in_size_blocks, in_block_index
//   result  | out       | out_valid, out_stall, out_status, out_block_address, out_inode_slot,
//           |           | out_free_blocks, out_file_count
// One request at a time: a create scans the inode table (up to NUM_INODES slots) and
// the block map (up to NUM_BLOCKS - 1 blocks); a delete frees its pointers one by one.
// Both scans, over the map and over the inode table, are serial.
// Reset restores the map and counts at once; no clearing pass.
// A stalled result holds; a new request is taken once the result is registered.
`default_nettype none
module inode_block_allocator_core import iba_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [63:0] in_file_name,
  input  wire logic [3:0]  in_size_blocks,
  input  wire logic [3:0]  in_block_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [2:0]  out_status,
  output logic      [6:0]  out_block_address,
  output logic      [3:0]  out_inode_slot,
  output logic      [6:0]  out_free_blocks,
  output logic      [4:0]  out_file_count
);
  cmd_t  cmd;
  stat_t st;

  iba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
  );

  iba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
    .in_kind(in_kind), .in_file_name(in_file_name), .in_size_blocks(in_size_blocks),
    .in_block_index(in_block_index), .out_status(out_status),
    .out_block_address(out_block_address), .out_inode_slot(out_inode_slot),
    .out_free_blocks(out_free_blocks), .out_file_count(out_file_count)
  );

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while idle did not start work");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)))
    else $error("stalled result changed");
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != 3'(ST_OK)) |-> (out_block_address == 7'd0))
    else $error("address on failed request");
endmodule
`default_nettype wire
